>>> rtl/rpc_pkg.sv
// Package: shared constants, types and the arctangent table for the converter.
package rpc_pkg;

  localparam int Stages    = 16;
  localparam int TableLen  = 24;
  localparam int NumStages = (Stages > TableLen) ? TableLen : Stages;
  localparam int DW        = 28;
  localparam int ZW        = 28;
  localparam int GainQ16   = 39797;

  localparam logic signed [ZW-1:0] Deg90  = 28'sd23592960;
  localparam logic signed [ZW-1:0] Deg180 = 28'sd47185920;

  localparam logic [1:0] ModeRect  = 2'd0;
  localparam logic [1:0] ModePolar = 2'd1;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 vec;
    logic                 bad;
    logic                 zero;
    logic signed [15:0]   v1;
    logic signed [15:0]   v2;
  } cell_data_t;

  function automatic logic signed [ZW-1:0] atan_at(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 28'sd11796480;  1: r = 28'sd6963869;  2: r = 28'sd3679517;
      3: r = 28'sd1867780;   4: r = 28'sd937515;   5: r = 28'sd469214;
      6: r = 28'sd234664;    7: r = 28'sd117339;   8: r = 28'sd58671;
      9: r = 28'sd29335;     10: r = 28'sd14668;   11: r = 28'sd7334;
      12: r = 28'sd3667;     13: r = 28'sd1833;    14: r = 28'sd917;
      15: r = 28'sd458;      16: r = 28'sd229;     17: r = 28'sd115;
      18: r = 28'sd57;       19: r = 28'sd29;      20: r = 28'sd14;
      21: r = 28'sd7;        22: r = 28'sd4;       23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rect_polar_converter_unit.sv
// Top level: rectangular/polar converter built as a chain of CORDIC cells.
// The converter accepts one request per clock while the output is not stalled and
// returns one result per request, in order, through one folding stage, one
// cell per micro-rotation, a gain multiply stage and a rounding/output register;
// by default there are 16 micro-rotations. The whole pipeline
// advances together, so it holds still whenever the output register is full and
// not taken; in_tready is high whenever the result register is empty or being
// read. Mode 0 takes (x, y) and returns magnitude and four-quadrant angle, mode 1
// takes (magnitude, angle) and returns x and y, and modes 2 and 3 return a zero
// vector with bad_mode set. Angles are in 1/64 degree, coordinates in Q8.8.
module rect_polar_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // first_value[15:0], second_value[31:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // coord_x, coord_y, magnitude(17), angle, zero fill
  output logic [1:0]  out_tuser   // form[0], bad_mode[1]
);

  localparam int N = rpc_pkg::NumStages;

  logic en;
  logic [N:0] vld;
  rpc_pkg::cell_data_t dat [N+1];
  logic [66:0] res;

  // The chain moves whenever the output register is free or being emptied.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  rpc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_tvalid),
    .mode    (in_tuser),
    .v1      (in_tdata[15:0]),
    .v2      (in_tdata[31:16]),
    .vld_out (vld[0]),
    .d_out   (dat[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .idx     (5'(i)),
      .vld_in  (vld[i]),
      .d_in    (dat[i]),
      .vld_out (vld[i+1]),
      .d_out   (dat[i+1])
    );
  end

  rpc_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld[N]),
    .d_in    (dat[N]),
    .vld_out (out_tvalid),
    .res     (res)
  );

  assign out_tdata = {7'd0, res[64:0]};
  assign out_tuser = {res[66], res[65]};

endmodule

>>> rtl/rpc_cell.sv
// One CORDIC micro-rotation cell; its shift and table index come from an input.
module rpc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [4:0]          idx,
  input  logic                vld_in,
  input  rpc_pkg::cell_data_t d_in,
  output logic                vld_out,
  output rpc_pkg::cell_data_t d_out
);

  logic                vld_r;
  rpc_pkg::cell_data_t d_r, d_nxt;
  logic signed [rpc_pkg::DW-1:0] dx, dy;
  logic neg;

  always_comb begin
    dx = d_in.y >>> idx;
    dy = d_in.x >>> idx;
    // Vectoring drives y to zero, rotation drives z to zero.
    neg = d_in.vec ? d_in.y[rpc_pkg::DW-1] : d_in.z[rpc_pkg::ZW-1];
    d_nxt = d_in;
    if (neg ^ !d_in.vec) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
    end
    if (neg) d_nxt.z = d_in.z + rpc_pkg::atan_at(int'(idx));
    else     d_nxt.z = d_in.z - rpc_pkg::atan_at(int'(idx));
    if (d_in.vec) begin
      if (neg) d_nxt.z = d_in.z - rpc_pkg::atan_at(int'(idx));
      else     d_nxt.z = d_in.z + rpc_pkg::atan_at(int'(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

>>> rtl/rpc_prep.sv
// Input stage: quadrant folding and scaling ahead of the cell chain.
module rpc_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  logic [1:0]          mode,
  input  logic signed [15:0]  v1,
  input  logic signed [15:0]  v2,
  output logic                vld_out,
  output rpc_pkg::cell_data_t d_out
);

  logic                vld_r;
  rpc_pkg::cell_data_t d_r, d_nxt;
  logic signed [16:0]  r0, r;
  logic signed [rpc_pkg::DW-1:0] sx, sy;

  always_comb begin
    sx = rpc_pkg::DW'(v1) <<< 8;
    sy = rpc_pkg::DW'(v2) <<< 8;
    // Wrap the angle into -180..180 degrees; |v2| < 2*23040 so one step suffices.
    r0 = 17'(v2);
    if (r0 >= 17'sd23040) r0 = r0 - 17'sd23040;
    else if (r0 <= -17'sd23040) r0 = r0 + 17'sd23040;
    r = r0;
    if (r > 17'sd11520) r = r - 17'sd23040;
    else if (r < -17'sd11520) r = r + 17'sd23040;

    d_nxt      = '0;
    d_nxt.v1   = v1;
    d_nxt.v2   = v2;
    d_nxt.zero = (v1 == 16'sd0) && (v2 == 16'sd0);
    d_nxt.bad  = (mode != rpc_pkg::ModeRect) && (mode != rpc_pkg::ModePolar);
    d_nxt.vec  = (mode == rpc_pkg::ModeRect);
    if (mode == rpc_pkg::ModeRect) begin
      d_nxt.x = sx;
      d_nxt.y = sy;
      if (v1 < 0) begin
        if (v2 >= 0) begin
          d_nxt.x = sy;  d_nxt.y = -sx; d_nxt.z = rpc_pkg::Deg90;
        end else begin
          d_nxt.x = -sy; d_nxt.y = sx;  d_nxt.z = -rpc_pkg::Deg90;
        end
      end
    end else begin
      d_nxt.x = sx;
      d_nxt.z = rpc_pkg::ZW'(r) <<< 12;
      if (r > 17'sd5760) begin
        d_nxt.x = -sx; d_nxt.z = d_nxt.z - rpc_pkg::Deg180;
      end else if (r < -17'sd5760) begin
        d_nxt.x = -sx; d_nxt.z = d_nxt.z + rpc_pkg::Deg180;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

>>> rtl/rpc_post.sv
// Output stages: gain correction (multiply, then round and clamp) and packing.
module rpc_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  rpc_pkg::cell_data_t d_in,
  output logic                vld_out,
  output logic [66:0]         res
);

  localparam int PW = rpc_pkg::DW + 17;

  logic                vld1_r, vld2_r;
  logic signed [PW-1:0] px_r, py_r;
  rpc_pkg::cell_data_t d1_r;
  logic [66:0]         res_r, res_nxt;
  logic signed [PW-1:0] gx, gy;
  logic signed [PW-1:0] ux, uy;
  logic signed [rpc_pkg::ZW-1:0] za;
  logic signed [15:0]  cx, cy, ang;
  logic signed [16:0]  mag;

  assign gx = PW'(d_in.x) * PW'(rpc_pkg::GainQ16);
  assign gy = PW'(d_in.y) * PW'(rpc_pkg::GainQ16);

  always_comb begin
    ux = (px_r + (PW'(1) <<< 23)) >>> 24;
    uy = (py_r + (PW'(1) <<< 23)) >>> 24;
    za = (d1_r.z + rpc_pkg::ZW'(2048)) >>> 12;
    cx = d1_r.v1; cy = d1_r.v2; mag = '0; ang = '0;
    if (d1_r.vec) begin
      if (!d1_r.zero) begin
        if (ux < 0) mag = '0;
        else if (ux > PW'(46341)) mag = 17'sd46341;
        else mag = 17'(ux);
        if (za < -rpc_pkg::ZW'(11520)) ang = -16'sd11520;
        else if (za > rpc_pkg::ZW'(11520)) ang = 16'sd11520;
        else ang = 16'(za);
      end
    end else begin
      mag = 17'(d1_r.v1);
      ang = d1_r.v2;
      cx = (ux < -PW'(32768)) ? -16'sd32768 : (ux > PW'(32767)) ? 16'sd32767 : 16'(ux);
      cy = (uy < -PW'(32768)) ? -16'sd32768 : (uy > PW'(32767)) ? 16'sd32767 : 16'(uy);
    end
    res_nxt = d1_r.bad ? {1'b1, 66'd0} :
              {1'b0, !d1_r.vec, ang, mag, cy, cx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
    end
    if (en) begin
      px_r  <= gx;
      py_r  <= gy;
      d1_r  <= d_in;
      res_r <= res_nxt;
    end
  end

  assign vld_out = vld2_r;
  assign res     = res_r;

endmodule

>>> sim/tb_top.sv
// Testbench for the rectangular/polar converter: directed and random vectors checked against a CORDIC predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] ModeBadA = 2'd2;
  localparam logic [1:0] ModeBadB = 2'd3;
  localparam int Latency = rpc_pkg::NumStages + 3;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [16:0] mag;
    logic signed [15:0] ang;
    logic               form;
    logic               bad;
  } vec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  vec_result_t expected_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int requests_sent = 0;

  rect_polar_converter_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint gain_fix(longint v);
    return shr(v * rpc_pkg::GainQ16 + (longint'(1) << 23), 24);
  endfunction

  // Computes the full converted vector for one request.
  function automatic vec_result_t convert_vector(logic [1:0] mode, logic signed [15:0] v1,
                                                 logic signed [15:0] v2);
    vec_result_t r;
    longint x, y, z, t, dx, dy, a;
    r = '0;
    if (mode == rpc_pkg::ModeRect) begin
      r.cx = v1;
      r.cy = v2;
      if (v1 != 0 || v2 != 0) begin
        x = longint'(v1) * 256;
        y = longint'(v2) * 256;
        z = 0;
        // Fold the left half plane onto the right before the micro-rotations.
        if (x < 0) begin
          if (y >= 0) begin
            t = x; x = y; y = -t; z = rpc_pkg::Deg90;
          end else begin
            t = x; x = -y; y = t; z = -rpc_pkg::Deg90;
          end
        end
        for (int i = 0; i < rpc_pkg::NumStages; i++) begin
          dx = shr(y, i);
          dy = shr(x, i);
          if (y < 0) begin
            x -= dx; y += dy; z -= rpc_pkg::atan_at(i);
          end else begin
            x += dx; y -= dy; z += rpc_pkg::atan_at(i);
          end
        end
        r.mag = 17'(clip(gain_fix(x), 0, 46341));
        r.ang = 16'(clip(shr(z + 2048, 12), -11520, 11520));
      end
    end else if (mode == rpc_pkg::ModePolar) begin
      r.mag = 17'(v1);
      r.ang = v2;
      r.form = 1'b1;
      a = longint'(v2) % 23040;
      if (a > 11520) a -= 23040;
      if (a < -11520) a += 23040;
      z = a * 4096;
      x = longint'(v1) * 256;
      y = 0;
      if (a > 5760) begin
        x = -x; z -= rpc_pkg::Deg180;
      end else if (a < -5760) begin
        x = -x; z += rpc_pkg::Deg180;
      end
      for (int i = 0; i < rpc_pkg::NumStages; i++) begin
        dx = shr(y, i);
        dy = shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= rpc_pkg::atan_at(i);
        end else begin
          x += dx; y -= dy; z += rpc_pkg::atan_at(i);
        end
      end
      r.cx = 16'(clip(gain_fix(x), -32768, 32767));
      r.cy = 16'(clip(gain_fix(y), -32768, 32767));
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  // Sends one request, with a random idle gap in front, and queues its expected result.
  task automatic send_vector(logic [1:0] mode, logic signed [15:0] v1, logic signed [15:0] v2);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v2, v1};
    in_tuser <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(convert_vector(mode, v1, v2));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // The receiver stalls at random, at the configured rate.
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    vec_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.cx = out_tdata[15:0];
      got.cy = out_tdata[31:16];
      got.mag = out_tdata[48:32];
      got.ang = out_tdata[64:49];
      got.form = out_tuser[0];
      got.bad = out_tuser[1];
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.cx !== exp_r.cx) begin
          $error("coord_x expected %0d got %0d", exp_r.cx, got.cx); errors++;
        end
        if (got.cy !== exp_r.cy) begin
          $error("coord_y expected %0d got %0d", exp_r.cy, got.cy); errors++;
        end
        if (got.mag !== exp_r.mag) begin
          $error("magnitude expected %0d got %0d", exp_r.mag, got.mag); errors++;
        end
        if (got.ang !== exp_r.ang) begin
          $error("angle expected %0d got %0d", exp_r.ang, got.ang); errors++;
        end
        if (got.form !== exp_r.form) begin
          $error("form expected %0d got %0d", exp_r.form, got.form); errors++;
        end
        if (got.bad !== exp_r.bad) begin
          $error("bad_mode expected %0d got %0d", exp_r.bad, got.bad); errors++;
        end
      end
    end
  end

  // Corners: axes, quadrant diagonals, zero vector, full-scale fields.
  task automatic test_rect_directed();
    send_vector(rpc_pkg::ModeRect, 16'sd0, 16'sd0);
    send_vector(rpc_pkg::ModeRect, 16'sd256, 16'sd0);
    send_vector(rpc_pkg::ModeRect, -16'sd256, 16'sd0);
    send_vector(rpc_pkg::ModeRect, 16'sd0, 16'sd256);
    send_vector(rpc_pkg::ModeRect, 16'sd0, -16'sd256);
    send_vector(rpc_pkg::ModeRect, -16'sd32768, -16'sd32768);
    send_vector(rpc_pkg::ModeRect, 16'sd32767, 16'sd32767);
    send_vector(rpc_pkg::ModeRect, -16'sd32768, 16'sd32767);
    send_vector(rpc_pkg::ModeRect, 16'sd32767, -16'sd32768);
    send_vector(rpc_pkg::ModeRect, -16'sd1, -16'sd1);
  endtask

  // Polar corners: wrapped angles, negative magnitude, saturation and the half-turn points.
  task automatic test_polar_directed();
    send_vector(rpc_pkg::ModePolar, 16'sd256, 16'sd0);
    send_vector(rpc_pkg::ModePolar, 16'sd32767, 16'sd5760);
    send_vector(rpc_pkg::ModePolar, 16'sd32767, 16'sd11520);
    send_vector(rpc_pkg::ModePolar, 16'sd32767, -16'sd11520);
    send_vector(rpc_pkg::ModePolar, -16'sd32768, 16'sd23040);
    send_vector(rpc_pkg::ModePolar, -16'sd32768, -16'sd23040);
    send_vector(rpc_pkg::ModePolar, 16'sd32767, 16'sd2880);
    send_vector(rpc_pkg::ModePolar, 16'sd1000, 16'sd32767);
    send_vector(rpc_pkg::ModePolar, 16'sd1000, -16'sd32768);
    send_vector(rpc_pkg::ModePolar, 16'sd0, 16'sd7000);
  endtask

  task automatic test_invalid_modes();
    send_vector(ModeBadA, 16'sd1234, 16'sd567);
    send_vector(ModeBadB, -16'sd1, -16'sd1);
  endtask

  // Random requests in both valid forms, with a few invalid ones and full-range fields.
  task automatic test_random(int count);
    logic [1:0] mode;
    logic signed [15:0] v1, v2;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      mode = pick < 47 ? rpc_pkg::ModeRect :
             (pick < 94 ? rpc_pkg::ModePolar : 2'($urandom_range(2, 3)));
      v1 = 16'($urandom);
      if ($urandom_range(3) == 0) v1 = 16'($signed(v1) >>> $urandom_range(14));
      if (mode == rpc_pkg::ModePolar && $urandom_range(9) != 0)
        v2 = 16'($signed(16'($urandom_range(46080))) - 23040);
      else
        v2 = 16'($urandom);
      send_vector(mode, v1, v2);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 59;
    test_rect_directed();
    test_polar_directed();
    test_invalid_modes();
    // Hold the sender off until the pipeline has drained completely.
    wait_drained();
    test_random(520);

    send_idle_pct = 59;
    recv_idle_pct = 7;
    test_random(520);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(590);

    wait_drained();
    repeat (Latency + 5) @(posedge clk);
    $display("Sent %0d conversions (rectangular, polar, invalid) and checked %0d results,",
             requests_sent, results_seen);
    $display("under sender stalls, receiver stalls and full-rate streaming.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("rect_polar_converter_unit regression: pass");
    end else begin
      $display("rect_polar_converter_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rect_polar_converter_unit regression: fail");
    $finish;
  end

endmodule
